@@ rtl/sfd_pkg.sv @@
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants, codes and types for the SLIP frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // SLIP special octets
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Result kinds
  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_EOF   = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  // Decoder modes (code 3 is unused and decodes as normal)
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_START  = 2'd1;
  localparam logic [1:0] MODE_END    = 2'd2;

  // Outcome of one decode step
  typedef struct packed {
    logic       emit;
    logic [1:0] kind;
    logic [7:0] byte_out;
    logic [1:0] mode_nxt;
    logic       esc_nxt;
  } step_t;

endpackage

@@ rtl/sfd_if.sv @@
// ----------------------------------------------------------------------------
// sfd_in_if / sfd_out_if
// Valid/ready channels: encoded octets in, decoded result words out.
// ----------------------------------------------------------------------------
interface sfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

interface sfd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] byte_out;

  modport source (output valid, output kind, output byte_out, input ready);
  modport sink   (input valid, input kind, input byte_out, output ready);
endinterface

@@ rtl/slip_frame_decoder.sv @@
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Removes SLIP framing: one encoded octet in, at most one result word out.
// ----------------------------------------------------------------------------
//  channel   dir  payload                    handshake
//  in_ch     in   byte_in[7:0]               valid/ready
//  out_ch    out  kind[1:0], byte_out[7:0]   valid/ready
//  cfg_*     in   with_start_delimiter       cfg_we, no wait
//
// One octet per clock while results are taken: an octet passes the input
// register, then is decoded into the result register. The decode is a few
// byte compares and a 2-bit mode update, so sfd_step gives the next mode and
// escape state combinationally. Reset is synchronous. A stalled result holds
// in the result register while one more octet waits in the input register.
// ----------------------------------------------------------------------------
module slip_frame_decoder (
  input  logic         clk,
  input  logic         rst_n,
  sfd_in_if.sink       in_ch,
  sfd_out_if.source    out_ch,
  input  logic         cfg_we,
  input  logic         cfg_wdata
);

  logic           delim_r;
  logic [1:0]     mode_r;
  logic           esc_r;
  logic           in_valid_r;
  logic [7:0]     in_byte_r;
  logic           out_valid_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_byte_r;
  logic           advance;
  sfd_pkg::step_t step;

  // Decode the held octet when the result slot is free or draining
  assign advance     = in_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !in_valid_r || advance;

  sfd_step u_step (
    .start_delim (delim_r),
    .mode        (mode_r),
    .esc_pending (esc_r),
    .byte_in     (in_byte_r),
    .step        (step)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      in_byte_r <= in_ch.byte_in;
    end
  end

  // Configuration and decoder state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delim_r <= 1'b0;
      mode_r  <= sfd_pkg::MODE_NORMAL;
      esc_r   <= 1'b0;
    end else if (cfg_we) begin
      delim_r <= cfg_wdata;
      mode_r  <= cfg_wdata ? sfd_pkg::MODE_START : sfd_pkg::MODE_NORMAL;
      esc_r   <= 1'b0;
    end else if (advance) begin
      mode_r  <= step.mode_nxt;
      esc_r   <= step.esc_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= step.emit;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step.emit) begin
      out_kind_r <= step.kind;
      out_byte_r <= step.byte_out;
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.byte_out = out_byte_r;

endmodule

@@ rtl/sfd_step.sv @@
// ----------------------------------------------------------------------------
// sfd_step
// Combinational decode of one octet against the current mode and escape flag.
// ----------------------------------------------------------------------------
module sfd_step (
  input  logic              start_delim,
  input  logic [1:0]        mode,
  input  logic              esc_pending,
  input  logic [7:0]        byte_in,
  output sfd_pkg::step_t    step
);

  logic [1:0] idle_mode;
  logic       is_end;

  assign idle_mode = start_delim ? sfd_pkg::MODE_START : sfd_pkg::MODE_NORMAL;
  assign is_end    = (byte_in == sfd_pkg::SLIP_END);

  // Decode one octet
  always_comb begin
    step.emit     = 1'b0;
    step.kind     = sfd_pkg::KIND_DATA;
    step.byte_out = 8'd0;
    step.mode_nxt = mode;
    step.esc_nxt  = esc_pending;
    unique case (mode)
      sfd_pkg::MODE_START: begin
        if (is_end) begin
          step.mode_nxt = sfd_pkg::MODE_NORMAL;
        end else begin
          step.mode_nxt = sfd_pkg::MODE_END;
          step.emit     = 1'b1;
          step.kind     = sfd_pkg::KIND_ERROR;
          step.byte_out = byte_in;
        end
      end
      sfd_pkg::MODE_END: begin
        // discard until frame end
        if (is_end) begin
          step.mode_nxt = idle_mode;
        end
      end
      default: begin
        if (esc_pending) begin
          step.esc_nxt = 1'b0;
          step.emit    = 1'b1;
          if (byte_in == sfd_pkg::SLIP_ESC_END) begin
            step.byte_out = sfd_pkg::SLIP_END;
          end else if (byte_in == sfd_pkg::SLIP_ESC_ESC) begin
            step.byte_out = sfd_pkg::SLIP_ESC;
          end else begin
            step.kind     = sfd_pkg::KIND_ERROR;
            step.byte_out = byte_in;
            step.mode_nxt = is_end ? idle_mode : sfd_pkg::MODE_END;
          end
        end else if (byte_in == sfd_pkg::SLIP_ESC) begin
          step.esc_nxt = 1'b1;
        end else if (is_end) begin
          step.emit     = 1'b1;
          step.kind     = sfd_pkg::KIND_EOF;
          step.mode_nxt = idle_mode;
        end else begin
          step.emit     = 1'b1;
          step.byte_out = byte_in;
        end
      end
    endcase
  end

endmodule

@@ rtl/sfd_checker.sv @@
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks on the SLIP frame decoder, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_kind,
  input logic [7:0] out_byte
);

  // Hold a stalled result word
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte))
    else $error("result word changed while stalled");

  // No result right after reset
  a_reset_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // Only the three defined kinds
  a_kind_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind != 2'd3)
    else $error("undefined result kind");

  // End of frame carries a zero byte
  a_eof_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == sfd_pkg::KIND_EOF |-> out_byte == 8'd0)
    else $error("end of frame with nonzero byte");

endmodule

bind slip_frame_decoder sfd_checker u_sfd_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_kind  (out_ch.kind),
  .out_byte  (out_ch.byte_out)
);
